// ----- rtl/srd_pkg.sv -----
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants for the sprite RLE pixel decoder.
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam int MAX_SIDE_DEFAULT = 64;
  localparam int SIDE_W           = 7;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 7;
  localparam int INDEX_W          = 12;
  localparam int COUNT_W          = 16;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [SIDE_W-1:0] SIDE_RESET   = 7'd32;
  localparam logic [7:0]        ALPHA_OPAQUE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_PRESENT = 1'b0,
    CFG_SPRITE_SIDE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_TLO  = 4'd0,
    PH_THI  = 4'd1,
    PH_CLO  = 4'd2,
    PH_CHI  = 4'd3,
    PH_RED  = 4'd4,
    PH_GRN  = 4'd5,
    PH_BLU  = 4'd6,
    PH_ALP  = 4'd7,
    PH_DONE = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

endpackage

// ----- rtl/srd_if.sv -----
// ----------------------------------------------------------------------------
// srd_if
// Valid/ready channels for byte input, pixel output and register writes.
// ----------------------------------------------------------------------------
interface srd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface srd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        pixel_write;
  logic [srd_pkg::INDEX_W-1:0] pixel_index;
  logic [7:0]                  red;
  logic [7:0]                  green;
  logic [7:0]                  blue;
  logic [7:0]                  alpha;
  logic                        sprite_end;

  modport source (output valid, pixel_write, pixel_index, red, green, blue, alpha,
                  sprite_end, input ready);
  modport sink   (input valid, pixel_write, pixel_index, red, green, blue, alpha,
                  sprite_end, output ready);
endinterface

interface srd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [srd_pkg::CFG_IDX_W-1:0]  index;
  logic [srd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/srd_front.sv -----
// ----------------------------------------------------------------------------
// srd_front
// Intake register: takes byte transfers and hands them to the queue.
// ----------------------------------------------------------------------------
module srd_front (
  input  logic              clk,
  input  logic              rst,
  srd_in_if.sink            pix_in,
  output logic              push_valid,
  input  logic              push_ready,
  output srd_pkg::item_t    push_item
);

  logic           held;
  srd_pkg::item_t item;

  assign pix_in.ready = !held || push_ready;
  assign push_valid   = held;
  assign push_item    = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (pix_in.valid && pix_in.ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.valid && pix_in.ready) begin
      item.data_byte  <= pix_in.data_byte;
      item.first_byte <= pix_in.first_byte;
      item.last_byte  <= pix_in.last_byte;
    end
  end

endmodule

// ----- rtl/srd_queue.sv -----
// ----------------------------------------------------------------------------
// srd_queue
// Short FIFO between the intake and the parser.
// ----------------------------------------------------------------------------
module srd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  srd_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output srd_pkg::item_t pop_item
);

  localparam int DEPTH = srd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  srd_pkg::item_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/srd_back.sv -----
// ----------------------------------------------------------------------------
// srd_back
// Run-length parser: one byte per cycle while not stalled; registered results.
// ----------------------------------------------------------------------------
module srd_back #(
  parameter int POS_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             alpha_present,
  input  logic [POS_W-1:0] area,
  input  logic             q_valid,
  output logic             q_ready,
  input  srd_pkg::item_t   q_item,
  srd_out_if.source        pix_out
);

  localparam int SUM_W = ((POS_W > srd_pkg::COUNT_W) ? POS_W : srd_pkg::COUNT_W) + 1;

  srd_pkg::phase_t               phase, phase_next, phase_in;
  logic [POS_W-1:0]              pos, pos_next, pos_in;
  logic [srd_pkg::COUNT_W-1:0]   remaining, remaining_next;
  logic [7:0]                    count_lo, count_lo_next;
  logic [7:0]                    held_red, held_red_next;
  logic [7:0]                    held_green, held_green_next;
  logic [7:0]                    held_blue, held_blue_next;
  logic [SUM_W-1:0]              skip_sum;
  logic [POS_W:0]                pos_inc;
  logic                          emit;
  logic [7:0]                    alpha_val;
  logic                          pop;

  logic                          o_valid;
  logic                          o_write;
  logic [srd_pkg::INDEX_W-1:0]   o_index;
  logic [7:0]                    o_red, o_green, o_blue, o_alpha;
  logic                          o_end;

  assign pop     = q_valid && (!o_valid || pix_out.ready);
  assign q_ready = pop;

  always_comb begin
    phase_in = q_item.first_byte ? srd_pkg::PH_TLO : phase;
    pos_in   = q_item.first_byte ? '0 : pos;
    if (phase_in != srd_pkg::PH_DONE && pos_in >= area) begin
      phase_in = srd_pkg::PH_DONE;
    end
    skip_sum = SUM_W'(pos_in) + SUM_W'({q_item.data_byte, count_lo});
    pos_inc  = {1'b0, pos_in} + 1'b1;

    phase_next      = phase_in;
    pos_next        = pos_in;
    remaining_next  = remaining;
    count_lo_next   = count_lo;
    held_red_next   = held_red;
    held_green_next = held_green;
    held_blue_next  = held_blue;
    emit            = 1'b0;
    alpha_val       = srd_pkg::ALPHA_OPAQUE;

    case (phase_in)
      srd_pkg::PH_TLO: begin
        count_lo_next = q_item.data_byte;
        phase_next    = srd_pkg::PH_THI;
      end
      srd_pkg::PH_THI: begin
        if (skip_sum >= SUM_W'(area)) begin
          pos_next   = area;
          phase_next = srd_pkg::PH_DONE;
        end else begin
          pos_next   = POS_W'(skip_sum);
          phase_next = srd_pkg::PH_CLO;
        end
      end
      srd_pkg::PH_CLO: begin
        count_lo_next = q_item.data_byte;
        phase_next    = srd_pkg::PH_CHI;
      end
      srd_pkg::PH_CHI: begin
        remaining_next = {q_item.data_byte, count_lo};
        phase_next     = (remaining_next != '0) ? srd_pkg::PH_RED : srd_pkg::PH_TLO;
      end
      srd_pkg::PH_RED: begin
        held_red_next = q_item.data_byte;
        phase_next    = srd_pkg::PH_GRN;
      end
      srd_pkg::PH_GRN: begin
        held_green_next = q_item.data_byte;
        phase_next      = srd_pkg::PH_BLU;
      end
      srd_pkg::PH_BLU: begin
        held_blue_next = q_item.data_byte;
        if (alpha_present && !q_item.last_byte) begin
          phase_next = srd_pkg::PH_ALP;
        end else begin
          emit = 1'b1;
        end
      end
      srd_pkg::PH_ALP: begin
        emit      = 1'b1;
        alpha_val = q_item.data_byte;
      end
      default: begin
        phase_next = srd_pkg::PH_DONE;
      end
    endcase

    if (emit) begin
      pos_next       = POS_W'(pos_inc);
      remaining_next = remaining - 1'b1;
      if (pos_inc >= {1'b0, area}) begin
        phase_next = srd_pkg::PH_DONE;
      end else begin
        phase_next = (remaining_next != '0) ? srd_pkg::PH_RED : srd_pkg::PH_TLO;
      end
    end

    if (q_item.last_byte) begin
      phase_next = srd_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= srd_pkg::PH_TLO;
      pos       <= '0;
      remaining <= '0;
      count_lo  <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase     <= phase_next;
        pos       <= pos_next;
        remaining <= remaining_next;
        count_lo  <= count_lo_next;
        o_valid   <= emit || q_item.last_byte;
      end else if (pix_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held_red   <= held_red_next;
      held_green <= held_green_next;
      held_blue  <= held_blue_next;
      o_write    <= emit;
      o_index    <= emit ? srd_pkg::INDEX_W'(pos_in) : '0;
      o_red      <= emit ? held_red_next : '0;
      o_green    <= emit ? held_green_next : '0;
      o_blue     <= emit ? held_blue_next : '0;
      o_alpha    <= emit ? alpha_val : '0;
      o_end      <= q_item.last_byte;
    end
  end

  assign pix_out.valid       = o_valid;
  assign pix_out.pixel_write = o_write;
  assign pix_out.pixel_index = o_index;
  assign pix_out.red         = o_red;
  assign pix_out.green       = o_green;
  assign pix_out.blue        = o_blue;
  assign pix_out.alpha       = o_alpha;
  assign pix_out.sprite_end  = o_end;

endmodule

// ----- rtl/sprite_rle_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// sprite_rle_pixel_decoder
// Decodes run-length compressed square sprites into colored pixel writes.
// ----------------------------------------------------------------------------
// Takes one compressed byte per clock and sustains that rate unless the
// output stalls; a byte passes the intake register, the queue and the
// output register on its way to a result. The figure is set by the parser
// in the back end, which takes one byte per cycle. A result comes for each
// finished colored pixel and for the byte flagged last; other bytes give
// none. Registers may be written only while the decoder is empty.
module sprite_rle_pixel_decoder #(
  parameter int MAX_SIDE = srd_pkg::MAX_SIDE_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  srd_in_if.sink     pix_in,
  srd_out_if.source  pix_out,
  srd_cfg_if.sink    cfg
);

  localparam int POS_W = $clog2(MAX_SIDE * MAX_SIDE + 1);

  logic                       alpha_present;
  logic [srd_pkg::SIDE_W-1:0] sprite_side;
  logic [srd_pkg::SIDE_W-1:0] side_clamped;
  logic [POS_W-1:0]           area;

  logic                       push_valid, push_ready;
  srd_pkg::item_t             push_item;
  logic                       q_valid, q_ready;
  srd_pkg::item_t             q_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_present <= 1'b0;
      sprite_side   <= srd_pkg::SIDE_RESET;
    end else if (cfg.valid) begin
      case (srd_pkg::cfg_reg_t'(cfg.index))
        srd_pkg::CFG_ALPHA_PRESENT: alpha_present <= cfg.data[0];
        srd_pkg::CFG_SPRITE_SIDE:   sprite_side   <= cfg.data[srd_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  assign side_clamped = (32'(sprite_side) > MAX_SIDE) ? srd_pkg::SIDE_W'(MAX_SIDE)
                                                      : sprite_side;

  always_ff @(posedge clk) begin
    area <= POS_W'(14'(side_clamped) * 14'(side_clamped));
  end

  srd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  srd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  srd_back #(
    .POS_W (POS_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .alpha_present (alpha_present),
    .area          (area),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .pix_out       (pix_out)
  );

  a_no_empty_result: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> (pix_out.pixel_write || pix_out.sprite_end))
    else $error("result with neither pixel nor end marker");

  a_blank_payload: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && !pix_out.pixel_write) |->
      (pix_out.pixel_index == '0 && pix_out.red == '0 && pix_out.green == '0 &&
       pix_out.blue == '0 && pix_out.alpha == '0))
    else $error("end-only result carries pixel data");

  a_idle_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !pix_out.valid)
    else $error("result valid right after reset");

endmodule

// ----- test/srd_decode_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srd_decode_checker
// Watches the byte, pixel and register channels of the sprite decoder.
// Every accepted byte runs through a local model of the RLE parser, and each
// result it should produce, pixel or end marker, is queued. Every result
// transfer is then compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module srd_decode_checker
  import srd_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  srd_in_if    in_ch,
  srd_out_if   out_ch,
  srd_cfg_if   cfg_ch,
  output int   pending,
  output int   errors,
  output int   results_seen
);

  typedef struct packed {
    logic                pixel_write;
    logic [INDEX_W-1:0]  pixel_index;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          alpha;
    logic                sprite_end;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  logic              alpha_on;
  logic [SIDE_W-1:0] side;

  phase_t            phase;
  logic [16:0]       position;
  logic [15:0]       remaining;
  logic [7:0]        low_byte;
  logic [7:0]        held_r;
  logic [7:0]        held_g;
  logic [7:0]        held_b;

  int err_count    = 0;
  int result_count = 0;

  task automatic restart_parser();
    phase     = PH_TLO;
    position  = '0;
    remaining = '0;
    low_byte  = '0;
    held_r    = '0;
    held_g    = '0;
    held_b    = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic first, input logic last);
    logic [SIDE_W-1:0] s;
    logic [16:0]       total;
    logic [17:0]       sum;
    logic              emit;
    logic [7:0]        alpha_v;
    logic [INDEX_W-1:0] idx;
    pixel_result_t     res;
    if (first) restart_parser();
    s = side;
    if (32'(side) > MAX_SIDE) s = SIDE_W'(MAX_SIDE);
    total   = 17'(s) * 17'(s);
    emit    = 1'b0;
    alpha_v = ALPHA_OPAQUE;
    idx     = '0;
    if (phase != PH_DONE && position >= total) phase = PH_DONE;
    case (phase)
      PH_TLO: begin
        low_byte = b;
        phase    = PH_THI;
      end
      PH_THI: begin
        sum = 18'(position) + 18'({b, low_byte});
        if (sum >= 18'(total)) begin
          position = total;
          phase    = PH_DONE;
        end else begin
          position = sum[16:0];
          phase    = PH_CLO;
        end
      end
      PH_CLO: begin
        low_byte = b;
        phase    = PH_CHI;
      end
      PH_CHI: begin
        remaining = {b, low_byte};
        phase     = (remaining != '0) ? PH_RED : PH_TLO;
      end
      PH_RED: begin
        held_r = b;
        phase  = PH_GRN;
      end
      PH_GRN: begin
        held_g = b;
        phase  = PH_BLU;
      end
      PH_BLU: begin
        held_b = b;
        if (alpha_on && !last) phase = PH_ALP;
        else emit = 1'b1;
      end
      PH_ALP: begin
        emit    = 1'b1;
        alpha_v = b;
      end
      default: phase = PH_DONE;
    endcase
    if (emit) begin
      idx       = position[INDEX_W-1:0];
      position  = position + 1'b1;
      remaining = remaining - 1'b1;
      if (position >= total) phase = PH_DONE;
      else phase = (remaining != '0) ? PH_RED : PH_TLO;
    end
    if (last) phase = PH_DONE;
    if (emit || last) begin
      res.pixel_write = emit;
      res.pixel_index = emit ? idx : '0;
      res.red         = emit ? held_r : '0;
      res.green       = emit ? held_g : '0;
      res.blue        = emit ? held_b : '0;
      res.alpha       = emit ? alpha_v : '0;
      res.sprite_end  = last;
      expected_pixels = {expected_pixels, res};
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (rst) begin
      restart_parser();
      alpha_on = 1'b0;
      side     = SIDE_RESET;
      expected_pixels.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_ALPHA_PRESENT) alpha_on = cfg_ch.data[0];
        else if (cfg_ch.index == CFG_SPRITE_SIDE) side = cfg_ch.data[SIDE_W-1:0];
      end
      if (in_ch.valid && in_ch.ready)
        decode_byte(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (expected_pixels.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, actual index %0d end %0b",
                   $time, out_ch.pixel_index, out_ch.sprite_end);
        end else begin
          exp_r = expected_pixels.pop_front();
          check_field("pixel_write", 16'(exp_r.pixel_write), 16'(out_ch.pixel_write));
          check_field("pixel_index", 16'(exp_r.pixel_index), 16'(out_ch.pixel_index));
          check_field("red", 16'(exp_r.red), 16'(out_ch.red));
          check_field("green", 16'(exp_r.green), 16'(out_ch.green));
          check_field("blue", 16'(exp_r.blue), 16'(out_ch.blue));
          check_field("alpha", 16'(exp_r.alpha), 16'(out_ch.alpha));
          check_field("sprite_end", 16'(exp_r.sprite_end), 16'(out_ch.sprite_end));
        end
      end
    end
    pending      <= expected_pixels.size();
    errors       <= err_count;
    results_seen <= result_count;
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sprite RLE pixel decoder. A short directed
// pass is followed by random sprites, mostly well formed with random runs
// and colors, mixed with truncated sprites, trailing bytes and noise, over
// many register settings. Input bursts and output stalls vary per phase.
// ----------------------------------------------------------------------------
module tb_top;
  import srd_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_GAP    = 8;

  logic clk = 1'b0;
  logic rst;

  srd_in_if  pix_in();
  srd_out_if pix_out();
  srd_cfg_if cfg();

  int chk_pending;
  int chk_errors;
  int chk_results;

  int cycle_count = 0;
  int burst_left  = 0;
  int items_sent  = 0;
  int sprite_count = 0;
  int setting_count = 0;
  int stall_mode;
  logic no_gaps;

  sprite_rle_pixel_decoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  srd_decode_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (pix_in),
    .out_ch       (pix_out),
    .cfg_ch       (cfg),
    .pending      (chk_pending),
    .errors       (chk_errors),
    .results_seen (chk_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sprite_rle_pixel_decoder test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (stall_mode)
      0:       pix_out.ready <= 1'b1;
      1:       pix_out.ready <= ($urandom_range(0, 3) != 0);
      2:       pix_out.ready <= ((cycle_count % 9) < 5);
      default: pix_out.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  function automatic item_t mk_item(input logic [7:0] b, input logic f, input logic l);
    item_t it;
    it.data_byte  = b;
    it.first_byte = f;
    it.last_byte  = l;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    pix_in.valid      <= 1'b1;
    pix_in.data_byte  <= it.data_byte;
    pix_in.first_byte <= it.first_byte;
    pix_in.last_byte  <= it.last_byte;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_regs(input logic alpha_on, input logic [SIDE_W-1:0] side);
    logic [CFG_DATA_W-2:0] junk;
    junk = (CFG_DATA_W-1)'($urandom_range(0, 63));
    cfg.valid <= 1'b1;
    cfg.index <= CFG_ALPHA_PRESENT;
    cfg.data  <= {junk, alpha_on};
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.index <= CFG_SPRITE_SIDE;
    cfg.data  <= side;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    setting_count++;
  endtask

  // one sprite: transparent/colored run records, then a randomly chosen ending
  task automatic play_sprite(input int area_px, input logic alpha_on);
    item_t       spr[$];
    int          pos;
    int          npix;
    int          ending;
    int          cut;
    logic [15:0] cnt;
    pos = 0;
    while (pos < area_px && spr.size() < 100) begin
      cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      spr = {spr, mk_item(cnt[7:0], 1'b0, 1'b0)};
      spr = {spr, mk_item(cnt[15:8], 1'b0, 1'b0)};
      pos += int'(cnt);
      if (pos >= area_px) break;
      cnt = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
      spr = {spr, mk_item(cnt[7:0], 1'b0, 1'b0)};
      spr = {spr, mk_item(cnt[15:8], 1'b0, 1'b0)};
      npix = int'(cnt);
      if (npix > area_px - pos) npix = area_px - pos;
      if (npix > 12) npix = 12;
      repeat (npix * (alpha_on ? 4 : 3)) spr = {spr, mk_item(8'($urandom), 1'b0, 1'b0)};
      pos += npix;
      if (npix < int'(cnt) && pos < area_px) break;
    end
    if (spr.size() == 0) spr = {spr, mk_item(8'($urandom), 1'b0, 1'b0)};
    ending = $urandom_range(0, 9);
    if (ending == 6 && spr.size() > 1) begin
      cut = $urandom_range(1, (spr.size() > 4) ? 3 : spr.size() - 1);
      repeat (cut) void'(spr.pop_back());
    end
    if (ending == 9)
      repeat ($urandom_range(1, 4)) spr = {spr, mk_item(8'($urandom), 1'b0, 1'b0)};
    if (ending != 7) spr[spr.size()-1].last_byte = 1'b1;
    if (ending == 8)
      repeat ($urandom_range(1, 3)) spr = {spr, mk_item(8'($urandom), 1'b0, 1'b0)};
    if ($urandom_range(0, 19) != 0) spr[0].first_byte = 1'b1;
    sprite_count++;
    foreach (spr[i]) send_item(spr[i]);
  endtask

  task automatic play_noise();
    repeat ($urandom_range(5, 20))
      send_item(mk_item(8'($urandom), ($urandom_range(0, 7) == 0),
                        ($urandom_range(0, 7) == 0)));
  endtask

  logic [7:0] seq_two [19] = '{8'h00, 8'h00, 8'h01, 8'h00, 8'hff, 8'h00, 8'h80, 8'h7f,
                               8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00,
                               8'h12, 8'h34, 8'haa};
  logic [7:0] seq_one [8]  = '{8'h00, 8'h00, 8'h01, 8'h00, 8'hff, 8'hff, 8'hff, 8'h66};

  initial begin
    int          phase_n;
    int          target;
    int          area_px;
    logic        alpha_on;
    logic [SIDE_W-1:0] side;
    logic [SIDE_W-1:0] eff;
    rst               = 1'b1;
    pix_in.valid      = 1'b0;
    pix_in.data_byte  = '0;
    pix_in.first_byte = 1'b0;
    pix_in.last_byte  = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = CFG_ALPHA_PRESENT;
    cfg.data          = '0;
    stall_mode        = 0;
    no_gaps           = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 2x2 with alpha, no first flag after reset; last lands on green, then a stray byte
    write_regs(1'b1, 7'd2);
    stall_mode <= 1;
    foreach (seq_two[i]) send_item(mk_item(seq_two[i], 1'b0, (i == 17)));
    wait_idle();
    // 1x1 without alpha: area filled, then last on an ignored byte
    write_regs(1'b0, 7'd1);
    foreach (seq_one[i]) send_item(mk_item(seq_one[i], (i == 0), (i == 7)));
    wait_idle();

    for (phase_n = 0; items_sent < ITEM_TARGET; phase_n++) begin
      case (phase_n)
        0: begin alpha_on = 1'b0; side = 7'd64; end
        1: begin alpha_on = 1'b1; side = 7'd1; end
        2: begin alpha_on = 1'b1; side = 7'd0; end
        3: begin alpha_on = 1'b0; side = 7'd127; end
        4: begin alpha_on = 1'b1; side = 7'd64; end
        default: begin
          alpha_on = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 9))
            0:       side = 7'd64;
            1:       side = SIDE_W'($urandom_range(0, 127));
            default: side = SIDE_W'($urandom_range(1, 12));
          endcase
        end
      endcase
      write_regs(alpha_on, side);
      stall_mode <= $urandom_range(0, 3);
      no_gaps = ($urandom_range(0, 3) == 0);
      eff = (32'(side) > MAX_SIDE_DEFAULT) ? SIDE_W'(MAX_SIDE_DEFAULT) : side;
      area_px = int'(eff) * int'(eff);
      target = items_sent + $urandom_range(60, 200);
      while (items_sent < target) begin
        if ($urandom_range(0, 9) == 0) play_noise();
        else play_sprite(area_px, alpha_on);
      end
      wait_idle();
    end

    $display("covered %0d sprites in %0d input bytes over %0d register settings",
             sprite_count, items_sent, setting_count);
    $display("checked %0d decoder results", chk_results);
    if (chk_errors == 0) begin
      $display("sprite_rle_pixel_decoder test passed");
    end else begin
      $display("sprite_rle_pixel_decoder test failed");
    end
    $finish;
  end

endmodule
